>>> rtl/z80alu_pkg.sv
// Shared types, operation codes and flag helpers for the 8-bit ALU with flags.
// No dependencies; imported by the core, the top level and the testbench.
package z80alu_pkg;

    localparam logic [4:0] OP_ADD  = 5'd0;
    localparam logic [4:0] OP_ADC  = 5'd1;
    localparam logic [4:0] OP_SUB  = 5'd2;
    localparam logic [4:0] OP_SBC  = 5'd3;
    localparam logic [4:0] OP_AND  = 5'd4;
    localparam logic [4:0] OP_XOR  = 5'd5;
    localparam logic [4:0] OP_OR   = 5'd6;
    localparam logic [4:0] OP_CP   = 5'd7;
    localparam logic [4:0] OP_RLC  = 5'd8;
    localparam logic [4:0] OP_RRC  = 5'd9;
    localparam logic [4:0] OP_RL   = 5'd10;
    localparam logic [4:0] OP_RR   = 5'd11;
    localparam logic [4:0] OP_SLA  = 5'd12;
    localparam logic [4:0] OP_SRA  = 5'd13;
    localparam logic [4:0] OP_SLL  = 5'd14;
    localparam logic [4:0] OP_SRL  = 5'd15;
    localparam logic [4:0] OP_RLCA = 5'd16;
    localparam logic [4:0] OP_RRCA = 5'd17;
    localparam logic [4:0] OP_RLA  = 5'd18;
    localparam logic [4:0] OP_RRA  = 5'd19;
    localparam logic [4:0] OP_DAA  = 5'd20;
    localparam logic [4:0] OP_CPL  = 5'd21;
    localparam logic [4:0] OP_SCF  = 5'd22;
    localparam logic [4:0] OP_CCF  = 5'd23;
    localparam logic [4:0] OP_INC  = 5'd24;
    localparam logic [4:0] OP_DEC  = 5'd25;

    localparam logic [8:0] DAA_SUB_HI = 9'h160;
    localparam logic [8:0] DAA_ADD_HI = 9'h060;
    localparam logic [8:0] DAA_LO_ADJ = 9'h006;
    localparam logic [8:0] DAA_HI_LIM = 9'h090;
    localparam logic [7:0] DAA_BCD_MAX = 8'h99;

    typedef struct packed {
        logic [4:0] operation;
        logic [7:0] accumulator_in;
        logic [7:0] operand;
        logic [7:0] flags_in;
    } alu_req_t;

    typedef struct packed {
        logic [7:0] result_byte;
        logic [7:0] flags_out;
    } alu_rsp_t;

    // sign, zero, bits 5 and 3, even parity; H, N and C clear
    function automatic logic [7:0] sz53p(input logic [7:0] v);
        return {v[7], (v == 8'd0), v[5], 1'b0, v[3], ~^v, 2'b00};
    endfunction

endpackage

>>> rtl/z80alu_if.sv
// Valid/ready channel interfaces for ALU requests and responses.
// Depends on nothing; the field widths match those in z80alu_pkg.
interface z80alu_req_if;
    logic       valid;
    logic       ready;
    logic [4:0] operation;
    logic [7:0] accumulator_in;
    logic [7:0] operand;
    logic [7:0] flags_in;

    modport source (output valid, output operation, output accumulator_in,
                    output operand, output flags_in, input ready);
    modport sink   (input valid, input operation, input accumulator_in,
                    input operand, input flags_in, output ready);
endinterface

interface z80alu_rsp_if;
    logic       valid;
    logic       ready;
    logic [7:0] result_byte;
    logic [7:0] flags_out;

    modport source (output valid, output result_byte, output flags_out, input ready);
    modport sink   (input valid, input result_byte, input flags_out, output ready);
endinterface

>>> rtl/z80alu_core.sv
// Combinational datapath of the ALU: result byte and new flag byte.
// Depends on z80alu_pkg (operation codes, request/response types, sz53p).
module z80alu_core (
    input  z80alu_pkg::alu_req_t req,
    output z80alu_pkg::alu_rsp_t rsp
);
    import z80alu_pkg::*;

    logic [7:0] a;
    logic [7:0] n;
    logic [7:0] f;
    logic       c;
    logic       is_sub;
    logic       cin;
    logic [8:0] t;
    logic [8:0] cb;
    logic [7:0] as_flags;
    logic [7:0] sh;
    logic       sh_c;
    logic [8:0] acu;
    logic       hf;
    logic       hd;
    logic [7:0] r;
    logic [7:0] nf;

    assign a = req.accumulator_in;
    assign n = req.operand;
    assign f = req.flags_in;
    assign c = f[0];

    assign is_sub = (req.operation == OP_SUB) || (req.operation == OP_SBC)
                 || (req.operation == OP_CP);
    assign cin    = ((req.operation == OP_ADC) || (req.operation == OP_SBC)) ? c : 1'b0;

    always_comb
    begin
        if (is_sub)
        begin
            t = {1'b0, a} - {1'b0, n} - {8'd0, cin};
        end
        else
        begin
            t = {1'b0, a} + {1'b0, n} + {8'd0, cin};
        end
        cb = {1'b0, a} ^ {1'b0, n} ^ t;
        as_flags = {t[7], (t[7:0] == 8'd0), t[5], cb[4], t[3], cb[8] ^ cb[7],
                    is_sub, cb[8]};
    end

    always_comb
    begin
        unique case (req.operation[2:0])
            3'd0:
            begin
                sh = {n[6:0], n[7]};
                sh_c = n[7];
            end
            3'd1:
            begin
                sh = {n[0], n[7:1]};
                sh_c = n[0];
            end
            3'd2:
            begin
                sh = {n[6:0], c};
                sh_c = n[7];
            end
            3'd3:
            begin
                sh = {c, n[7:1]};
                sh_c = n[0];
            end
            3'd4:
            begin
                sh = {n[6:0], 1'b0};
                sh_c = n[7];
            end
            3'd5:
            begin
                sh = {n[7], n[7:1]};
                sh_c = n[0];
            end
            3'd6:
            begin
                sh = {n[6:0], 1'b1};
                sh_c = n[7];
            end
            default:
            begin
                sh = {1'b0, n[7:1]};
                sh_c = n[0];
            end
        endcase
    end

    // decimal adjust after add or subtract
    always_comb
    begin
        acu = {1'b0, a};
        hf  = f[4];
        hd  = c || (a > DAA_BCD_MAX);
        if (f[1])
        begin
            if (hf || (a[3:0] > 4'd9))
            begin
                if (a[3:0] > 4'd5)
                begin
                    hf = 1'b0;
                end
                acu = {1'b0, a - DAA_LO_ADJ[7:0]};
            end
            if (hd)
            begin
                acu = acu - DAA_SUB_HI;
            end
        end
        else
        begin
            if (hf || (a[3:0] > 4'd9))
            begin
                hf  = (a[3:0] > 4'd9);
                acu = acu + DAA_LO_ADJ;
            end
            if (c || ({acu[8:4], 4'd0} > DAA_HI_LIM))
            begin
                acu = acu + DAA_ADD_HI;
            end
        end
    end

    always_comb
    begin
        r  = a;
        nf = f;
        unique case (req.operation)
            OP_ADD, OP_ADC, OP_SUB, OP_SBC:
            begin
                r  = t[7:0];
                nf = as_flags;
            end
            OP_AND:
            begin
                r  = a & n;
                nf = sz53p(a & n) | 8'h10;
            end
            OP_XOR:
            begin
                r  = a ^ n;
                nf = sz53p(a ^ n);
            end
            OP_OR:
            begin
                r  = a | n;
                nf = sz53p(a | n);
            end
            OP_CP:
            begin
                nf = {as_flags[7:6], n[5], as_flags[4], n[3], as_flags[2:0]};
            end
            OP_RLC, OP_RRC, OP_RL, OP_RR, OP_SLA, OP_SRA, OP_SLL, OP_SRL:
            begin
                r  = sh;
                nf = sz53p(sh) | {7'd0, sh_c};
            end
            OP_RLCA:
            begin
                r  = {a[6:0], a[7]};
                nf = {f[7:6], a[4], 1'b0, a[2], f[2], 1'b0, a[7]};
            end
            OP_RRCA:
            begin
                r  = {a[0], a[7:1]};
                nf = {f[7:6], a[6], 1'b0, a[4], f[2], 1'b0, a[0]};
            end
            OP_RLA:
            begin
                r  = {a[6:0], c};
                nf = {f[7:6], a[4], 1'b0, a[2], f[2], 1'b0, a[7]};
            end
            OP_RRA:
            begin
                r  = {c, a[7:1]};
                nf = {f[7:6], a[6], 1'b0, a[4], f[2], 1'b0, a[0]};
            end
            OP_DAA:
            begin
                r  = acu[7:0];
                nf = sz53p(acu[7:0]) | {3'd0, hf, 2'd0, f[1], c | acu[8]};
            end
            OP_CPL:
            begin
                r  = ~a;
                nf = {f[7:6], ~a[5], 1'b1, ~a[3], f[2], 1'b1, f[0]};
            end
            OP_SCF:
            begin
                nf = {f[7:6], a[5], 1'b0, a[3], f[2], 1'b0, 1'b1};
            end
            OP_CCF:
            begin
                nf = {f[7:6], a[5], c, a[3], f[2], 1'b0, ~c};
            end
            OP_INC:
            begin
                r  = n + 8'd1;
                nf = {r[7], (r == 8'd0), r[5], (r[3:0] == 4'h0), r[3],
                      (r == 8'h80), 1'b0, f[0]};
            end
            OP_DEC:
            begin
                r  = n - 8'd1;
                nf = {r[7], (r == 8'd0), r[5], (r[3:0] == 4'hf), r[3],
                      (r == 8'h7f), 1'b1, f[0]};
            end
            default:
            begin
                r  = a;
                nf = f;
            end
        endcase
    end

    assign rsp.result_byte = r;
    assign rsp.flags_out   = nf;

endmodule

>>> rtl/cpu_alu_8bit_with_flags.sv
// Top level of the 8-bit ALU with flags: input register, core, result register.
// Depends on z80alu_pkg, z80alu_req_if, z80alu_rsp_if and z80alu_core.
//
// Usage:
//   req channel: operation, accumulator_in, operand, flags_in; a transfer
//     happens when req.valid and req.ready are both high at a rising edge.
//   rsp channel: result_byte and flags_out, one response per request, in order.
//   Path: an accepted request enters the input register, then passes the ALU
//     logic into the result register, which drives rsp.valid; the response
//     transfers when rsp.valid and rsp.ready are both high at a rising edge.
//   Throughput: one request per cycle while rsp.ready is high; the input and
//     result registers form a two-entry pipeline with per-stage valid bits.
//   Stall: with rsp.ready low the result register holds; the input register
//     still takes one more request, after which req.ready drops until the
//     result is taken.
//   Reset: rst_n low clears both valid bits; nothing is in flight afterwards.
//   Unused operation codes pass the accumulator and flags through unchanged.
module cpu_alu_8bit_with_flags (
    input  logic         clk,
    input  logic         rst_n,
    z80alu_req_if.sink   req,
    z80alu_rsp_if.source rsp
);
    import z80alu_pkg::*;

    logic     s1_valid_reg;
    logic     s1_valid_next;
    alu_req_t s1_data_reg;
    logic     rsp_valid_reg;
    logic     rsp_valid_next;
    alu_rsp_t rsp_data_reg;
    alu_rsp_t core_rsp;
    logic     s1_ready;
    logic     s2_ready;

    assign s2_ready  = !rsp_valid_reg || rsp.ready;
    assign s1_ready  = !s1_valid_reg || s2_ready;
    assign req.ready = s1_ready;

    assign s1_valid_next  = s1_ready ? req.valid : s1_valid_reg;
    assign rsp_valid_next = s2_ready ? s1_valid_reg : rsp_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.valid && s1_ready)
        begin
            s1_data_reg <= '{operation:      req.operation,
                             accumulator_in: req.accumulator_in,
                             operand:        req.operand,
                             flags_in:       req.flags_in};
        end
        if (s1_valid_reg && s2_ready)
        begin
            rsp_data_reg <= core_rsp;
        end
    end

    z80alu_core u_core (
        .req (s1_data_reg),
        .rsp (core_rsp)
    );

    assign rsp.valid       = rsp_valid_reg;
    assign rsp.result_byte = rsp_data_reg.result_byte;
    assign rsp.flags_out   = rsp_data_reg.flags_out;

    a_req_fills_s1: assert property (@(posedge clk) disable iff (!rst_n)
        (req.valid && req.ready) |=> s1_valid_reg)
        else $error("accepted request did not reach the input register");

    a_s1_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && !s2_ready) |=> (s1_valid_reg && $stable(s1_data_reg)))
        else $error("input register changed while stalled");

    a_s1_moves: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && s2_ready) |=> rsp_valid_reg)
        else $error("advanced item did not reach the result register");

    a_full_blocks: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && rsp_valid_reg && !rsp.ready) |-> !req.ready)
        else $error("request taken while both stages are full and stalled");

endmodule

>>> verif/cpu_alu_8bit_with_flags_tb.sv
// Self-checking testbench for cpu_alu_8bit_with_flags: directed and random ALU requests
// with random stalls on both channels, each result checked against a local predictor.
// Depends on z80alu_pkg, z80alu_req_if, z80alu_rsp_if and the top level of the block.
module cpu_alu_8bit_with_flags_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import z80alu_pkg::*;

    localparam int CYCLE_LIMIT = 200000;

    typedef struct {
        alu_req_t op;
        alu_rsp_t want;
    } alu_check_t;

    logic clk = 1'b0;
    logic rst_n;

    z80alu_req_if req_ch();
    z80alu_rsp_if rsp_ch();

    cpu_alu_8bit_with_flags u_top (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch)
    );

    alu_req_t   pending_ops[$];
    alu_check_t awaited_results[$];
    alu_req_t   next_req;
    int         send_gap;
    int         take_gap;
    int         mismatches;
    int         results_checked;
    int         cycle_count;
    logic       quiet_tail;
    logic [31:0] ops_seen = '0;

    always #6 clk = ~clk;

    function automatic logic [7:0] szp_of(input logic [7:0] v);
        return (v & 8'hA8) | ((v == 8'h00) ? 8'h40 : 8'h00) | ((^v) ? 8'h00 : 8'h04);
    endfunction

    function automatic logic [15:0] arith_result(input logic [7:0] a, input logic [7:0] n,
                                                 input logic cin, input logic borrow);
        logic [8:0] sum;
        logic [8:0] cb;
        logic [7:0] fl;
        sum = borrow ? ({1'b0, a} - {1'b0, n} - cin) : ({1'b0, a} + {1'b0, n} + cin);
        cb  = {1'b0, a} ^ {1'b0, n} ^ sum;
        fl  = (sum[7:0] & 8'hA8) | ((sum[7:0] == 8'h00) ? 8'h40 : 8'h00)
            | {3'b000, cb[4], 4'b0000} | {5'b00000, cb[8] ^ cb[7], 2'b00}
            | {6'b000000, borrow, 1'b0} | {7'b0000000, cb[8]};
        return {sum[7:0], fl};
    endfunction

    function automatic alu_rsp_t predict_alu(input alu_req_t rq);
        logic [7:0]  a;
        logic [7:0]  n;
        logic [7:0]  f;
        logic [7:0]  r;
        logic [7:0]  nf;
        logic [15:0] rf;
        logic        c;
        logic        hf;
        logic [8:0]  acu;
        alu_rsp_t    rsp;
        a  = rq.accumulator_in;
        n  = rq.operand;
        f  = rq.flags_in;
        c  = f[0];
        r  = a;
        nf = f;
        case (rq.operation)
            OP_ADD: {r, nf} = arith_result(a, n, 1'b0, 1'b0);
            OP_ADC: {r, nf} = arith_result(a, n, c, 1'b0);
            OP_SUB: {r, nf} = arith_result(a, n, 1'b0, 1'b1);
            OP_SBC: {r, nf} = arith_result(a, n, c, 1'b1);
            OP_AND:
            begin
                r  = a & n;
                nf = szp_of(r) | 8'h10;
            end
            OP_XOR:
            begin
                r  = a ^ n;
                nf = szp_of(r);
            end
            OP_OR:
            begin
                r  = a | n;
                nf = szp_of(r);
            end
            OP_CP:
            begin
                rf = arith_result(a, n, 1'b0, 1'b1);
                nf = (rf[7:0] & 8'hD7) | (n & 8'h28);
            end
            OP_RLC:
            begin
                r  = {n[6:0], n[7]};
                nf = szp_of(r) | {7'b0000000, n[7]};
            end
            OP_RRC:
            begin
                r  = {n[0], n[7:1]};
                nf = szp_of(r) | {7'b0000000, n[0]};
            end
            OP_RL:
            begin
                r  = {n[6:0], c};
                nf = szp_of(r) | {7'b0000000, n[7]};
            end
            OP_RR:
            begin
                r  = {c, n[7:1]};
                nf = szp_of(r) | {7'b0000000, n[0]};
            end
            OP_SLA:
            begin
                r  = {n[6:0], 1'b0};
                nf = szp_of(r) | {7'b0000000, n[7]};
            end
            OP_SRA:
            begin
                r  = {n[7], n[7:1]};
                nf = szp_of(r) | {7'b0000000, n[0]};
            end
            OP_SLL:
            begin
                r  = {n[6:0], 1'b1};
                nf = szp_of(r) | {7'b0000000, n[7]};
            end
            OP_SRL:
            begin
                r  = {1'b0, n[7:1]};
                nf = szp_of(r) | {7'b0000000, n[0]};
            end
            OP_RLCA:
            begin
                r  = {a[6:0], a[7]};
                nf = (f & 8'hC4) | (r & 8'h28) | {7'b0000000, a[7]};
            end
            OP_RRCA:
            begin
                r  = {a[0], a[7:1]};
                nf = (f & 8'hC4) | (r & 8'h28) | {7'b0000000, a[0]};
            end
            OP_RLA:
            begin
                r  = {a[6:0], c};
                nf = (f & 8'hC4) | (r & 8'h28) | {7'b0000000, a[7]};
            end
            OP_RRA:
            begin
                r  = {c, a[7:1]};
                nf = (f & 8'hC4) | (r & 8'h28) | {7'b0000000, a[0]};
            end
            OP_DAA:
            begin
                acu = {1'b0, a};
                hf  = f[4];
                if (f[1])
                begin
                    if (hf || a[3:0] > 4'd9)
                    begin
                        if (a[3:0] > 4'd5)
                            hf = 1'b0;
                        acu = {1'b0, a - 8'd6};
                    end
                    if (c || a > 8'h99)
                        acu = acu - 9'h160;
                end
                else
                begin
                    if (hf || a[3:0] > 4'd9)
                    begin
                        hf  = (a[3:0] > 4'd9);
                        acu = acu + 9'd6;
                    end
                    if (c || (acu & 9'h1F0) > 9'h090)
                        acu = acu + 9'h060;
                end
                r  = acu[7:0];
                nf = szp_of(r) | {3'b000, hf, 4'b0000} | (f & 8'h02)
                   | {7'b0000000, c | acu[8]};
            end
            OP_CPL:
            begin
                r  = ~a;
                nf = (f & 8'hC5) | (r & 8'h28) | 8'h12;
            end
            OP_SCF: nf = (f & 8'hC4) | (a & 8'h28) | 8'h01;
            OP_CCF: nf = (f & 8'hC4) | (a & 8'h28) | {3'b000, c, 3'b000, ~c};
            OP_INC:
            begin
                r  = n + 8'd1;
                nf = {7'b0000000, c} | (r & 8'hA8) | ((r == 8'h00) ? 8'h40 : 8'h00)
                   | ((r[3:0] == 4'h0) ? 8'h10 : 8'h00) | ((r == 8'h80) ? 8'h04 : 8'h00);
            end
            OP_DEC:
            begin
                r  = n - 8'd1;
                nf = {7'b0000000, c} | (r & 8'hA8) | ((r == 8'h00) ? 8'h40 : 8'h00)
                   | ((r[3:0] == 4'hF) ? 8'h10 : 8'h00) | ((r == 8'h7F) ? 8'h04 : 8'h00)
                   | 8'h02;
            end
            default: ;
        endcase
        rsp.result_byte = r;
        rsp.flags_out   = nf;
        return rsp;
    endfunction

    function automatic logic [7:0] pick_byte();
        case ($urandom_range(0, 7))
            0: return 8'h00;
            1: return 8'hFF;
            2: return $urandom_range(0, 1) ? 8'h7F : 8'h80;
            3: return {4'($urandom_range(0, 9)), 4'($urandom_range(0, 9))};
            default: return 8'($urandom);
        endcase
    endfunction

    task automatic add_item(input logic [4:0] op, input logic [7:0] a, input logic [7:0] n,
                            input logic [7:0] f);
        alu_req_t item;
        item.operation      = op;
        item.accumulator_in = a;
        item.operand        = n;
        item.flags_in       = f;
        pending_ops.push_back(item);
    endtask

    task automatic add_random_item();
        logic [4:0] op;
        if ($urandom_range(0, 9) == 0)
            op = 5'($urandom_range(26, 31));
        else
            op = 5'($urandom_range(0, 25));
        add_item(op, pick_byte(), pick_byte(), 8'($urandom));
    endtask

    task automatic record_transfer(input alu_req_t sent);
        alu_check_t entry;
        entry.op   = sent;
        entry.want = predict_alu(sent);
        awaited_results.push_back(entry);
    endtask

    task automatic check_result(input alu_rsp_t got);
        alu_check_t entry;
        if (awaited_results.size() == 0)
        begin
            $display("%0t: result %h flags %h arrived with nothing outstanding",
                     $time, got.result_byte, got.flags_out);
            mismatches++;
        end
        else
        begin
            entry = awaited_results.pop_front();
            ops_seen[entry.op.operation] = 1'b1;
            results_checked++;
            if (got.result_byte !== entry.want.result_byte)
            begin
                $display("%0t: op %0d a=%h n=%h f=%h result expected %h actual %h", $time,
                         entry.op.operation, entry.op.accumulator_in, entry.op.operand,
                         entry.op.flags_in, entry.want.result_byte, got.result_byte);
                mismatches++;
            end
            if (got.flags_out !== entry.want.flags_out)
            begin
                $display("%0t: op %0d a=%h n=%h f=%h flags expected %h actual %h", $time,
                         entry.op.operation, entry.op.accumulator_in, entry.op.operand,
                         entry.op.flags_in, entry.want.flags_out, got.flags_out);
                mismatches++;
            end
        end
    endtask

    task automatic wait_drained();
        while (pending_ops.size() != 0 || req_ch.valid || awaited_results.size() != 0)
            @(posedge clk);
    endtask

    // request driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req_ch.valid <= 1'b0;
            send_gap     <= 0;
        end
        else if (!req_ch.valid || req_ch.ready)
        begin
            if (req_ch.valid)
                record_transfer({req_ch.operation, req_ch.accumulator_in, req_ch.operand,
                                 req_ch.flags_in});
            if (send_gap > 0)
            begin
                send_gap     <= send_gap - 1;
                req_ch.valid <= 1'b0;
            end
            else if (pending_ops.size() == 0)
                req_ch.valid <= 1'b0;
            else if (!quiet_tail && $urandom_range(0, 5) == 0)
            begin
                send_gap     <= $urandom_range(0, 7);
                req_ch.valid <= 1'b0;
            end
            else
            begin
                next_req               = pending_ops.pop_front();
                req_ch.valid          <= 1'b1;
                req_ch.operation      <= next_req.operation;
                req_ch.accumulator_in <= next_req.accumulator_in;
                req_ch.operand        <= next_req.operand;
                req_ch.flags_in       <= next_req.flags_in;
            end
        end
    end

    // response monitor
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_ch.ready <= 1'b0;
            take_gap     <= 0;
        end
        else
        begin
            if (rsp_ch.valid && rsp_ch.ready)
                check_result({rsp_ch.result_byte, rsp_ch.flags_out});
            if (take_gap > 0)
            begin
                take_gap     <= take_gap - 1;
                rsp_ch.ready <= 1'b0;
            end
            else if (!quiet_tail && $urandom_range(0, 5) == 0)
            begin
                take_gap     <= $urandom_range(0, 7);
                rsp_ch.ready <= 1'b0;
            end
            else
                rsp_ch.ready <= 1'b1;
        end
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("[cpu_alu_8bit_with_flags] ERROR");
            $finish;
        end
    end

    initial
    begin
        int idx;
        rst_n      = 1'b0;
        quiet_tail = 1'b0;

        add_item(OP_ADD,  8'h7F, 8'h01, 8'h00);
        add_item(OP_ADD,  8'hFF, 8'h01, 8'hFF);
        add_item(OP_ADC,  8'hFF, 8'h00, 8'h01);
        add_item(OP_SUB,  8'h80, 8'h01, 8'h00);
        add_item(OP_SBC,  8'h00, 8'h00, 8'h01);
        add_item(OP_AND,  8'hFF, 8'hFF, 8'h00);
        add_item(OP_XOR,  8'h5A, 8'h5A, 8'hFF);
        add_item(OP_OR,   8'h00, 8'h00, 8'hFF);
        add_item(OP_CP,   8'h10, 8'h28, 8'h00);
        add_item(OP_CP,   8'h42, 8'h42, 8'hFF);
        add_item(OP_RLC,  8'h00, 8'h80, 8'h00);
        add_item(OP_RRC,  8'hFF, 8'h01, 8'h00);
        add_item(OP_RL,   8'h00, 8'h80, 8'h01);
        add_item(OP_RR,   8'h00, 8'h01, 8'h01);
        add_item(OP_SLA,  8'h00, 8'hFF, 8'h00);
        add_item(OP_SRA,  8'h00, 8'h80, 8'h00);
        add_item(OP_SLL,  8'h00, 8'h00, 8'h00);
        add_item(OP_SRL,  8'h00, 8'h01, 8'hFF);
        add_item(OP_RLCA, 8'h81, 8'h00, 8'hFF);
        add_item(OP_RRCA, 8'h51, 8'h00, 8'h00);
        add_item(OP_RLA,  8'h80, 8'h00, 8'h01);
        add_item(OP_RRA,  8'h01, 8'h00, 8'h00);
        add_item(OP_DAA,  8'h9A, 8'h00, 8'h00);
        add_item(OP_DAA,  8'hFA, 8'h00, 8'h13);
        add_item(OP_CPL,  8'h00, 8'h00, 8'h00);
        add_item(OP_SCF,  8'h28, 8'h00, 8'h00);
        add_item(OP_CCF,  8'hD7, 8'h00, 8'h01);
        add_item(OP_INC,  8'h00, 8'h7F, 8'h01);
        add_item(OP_DEC,  8'h00, 8'h00, 8'h00);
        add_item(5'd31,   8'h55, 8'hAA, 8'hAA);

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        wait_drained();
        @(negedge clk);
        for (idx = 0; idx < 400; idx++)
            add_random_item();

        wait_drained();
        @(negedge clk);
        for (idx = 0; idx < 350; idx++)
            add_random_item();

        while (pending_ops.size() > 100)
            @(negedge clk);
        quiet_tail = 1'b1;

        wait_drained();
        repeat (8) @(posedge clk);

        $display("%0d results checked over %0d distinct operation codes,", results_checked,
                 $countones(ops_seen));
        $display("with random stall bursts on both channels and full drains between phases");
        if (mismatches == 0)
            $display("[cpu_alu_8bit_with_flags] OK");
        else
            $display("[cpu_alu_8bit_with_flags] ERROR");
        $finish;
    end

endmodule
